@@ hdl/nvqte_pkg.sv @@
// Shared types and constants for the NVMe I/O queue transfer engine.
// Used by the front, the task queue, the back and the top level.
// No dependencies.
package nvqte_pkg;

    // Result kinds, carried on m_tuser.
    localparam logic [1:0] KIND_SUBMIT   = 2'd0;
    localparam logic [1:0] KIND_DOORBELL = 2'd1;
    localparam logic [1:0] KIND_FINISHED = 2'd2;

    // Request completion codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NODEV = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_IOERR = 2'd3;

    // Command opcodes.
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Input modes, carried on s_tuser.
    localparam logic MODE_REQUEST = 1'b0;
    localparam logic MODE_STATUS  = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] REG_NAMESPACE_COUNT   = 3'd0;
    localparam logic [2:0] REG_NAMESPACE_ID      = 3'd1;
    localparam logic [2:0] REG_NAMESPACE_SECTORS = 3'd2;
    localparam logic [2:0] REG_BUFFER_ADDRESS    = 3'd3;
    localparam logic [2:0] REG_POLL_LIMIT        = 3'd4;

    // Configuration reset values.
    localparam logic [21:0] POLL_LIMIT_RESET = 22'd4000000;

    // Bounce buffer page geometry.
    localparam logic [63:0] PAGE_BYTES       = 64'd4096;
    localparam logic [4:0]  SECTORS_PER_PAGE = 5'd8;

    // Depth of the queue between front and back.
    localparam int TASK_FIFO_DEPTH = 4;

    // One result item, kind excluded from nothing.
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  opcode;
        logic [63:0] command_lba;
        logic [3:0]  blocks_minus_one;
        logic [63:0] second_page_address;
        logic [3:0]  doorbell_value;
        logic [1:0]  request_status;
        logic [10:0] device_status;
    } result_t;

    // The results caused by one accepted input item.
    typedef struct packed {
        logic    two;
        result_t first;
        result_t second;
    } task_t;

endpackage

@@ hdl/nvqte_front.sv @@
// Front of the transfer engine: configuration registers, queue state and
// the per-item decision that turns an accepted input into one or two results.
// Depends on nvqte_pkg.
module nvqte_front #(
    parameter int QUEUE_DEPTH       = 16,
    parameter int MAX_CHUNK_SECTORS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_wr_data,
    input  logic                in_fire,
    input  logic                in_mode,
    input  logic [3:0]          in_namespace_index,
    input  logic [63:0]         in_start_lba,
    input  logic [31:0]         in_sector_count,
    input  logic                in_is_write,
    input  logic [15:0]         in_completion_status,
    output logic                task_push,
    output nvqte_pkg::task_t    task_data
);

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam logic [4:0] MAX_CHUNK = 5'(MAX_CHUNK_SECTORS);

    // Configuration registers; the namespace identifier reaches no result
    // field, so it is not stored.
    logic        ns_count_reg;
    logic [63:0] ns_sectors_reg;
    logic [63:0] buf_addr_reg;
    logic [21:0] poll_limit_reg;

    // Queue and request state.
    logic [QW-1:0] tail_reg, tail_next;
    logic [QW-1:0] head_reg, head_next;
    logic          phase_reg, phase_next;
    logic          busy_reg, busy_next;
    logic [63:0]   lba_reg, lba_next;
    logic [31:0]   left_reg, left_next;
    logic [4:0]    chunk_reg, chunk_next;
    logic          wflag_reg, wflag_next;
    logic [21:0]   polls_reg, polls_next;

    // Shared submit datapath signals.
    logic [31:0]   sub_left;
    logic [63:0]   sub_lba;
    logic          sub_write;
    logic [4:0]    chunk;
    logic [QW-1:0] tail_inc;
    logic [QW-1:0] head_inc;
    logic [QW+3:0] tail_ext;
    logic [QW+3:0] head_ext;
    logic [21:0]   poll_load;
    logic [21:0]   poll_dec;
    logic [31:0]   left_after;
    logic [63:0]   lba_after;
    logic          range_bad;
    logic [10:0]   code;
    nvqte_pkg::result_t submit_res;
    nvqte_pkg::result_t bell_res;
    nvqte_pkg::result_t finish_res;
    logic [1:0]    finish_status;
    logic [10:0]   finish_code;

    function automatic logic [QW-1:0] wrap_inc(input logic [QW-1:0] v);
        wrap_inc = (v == QW'(QUEUE_DEPTH - 1)) ? '0 : v + 1'b1;
    endfunction

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ns_count_reg   <= 1'b0;
            ns_sectors_reg <= '0;
            buf_addr_reg   <= '0;
            poll_limit_reg <= nvqte_pkg::POLL_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                nvqte_pkg::REG_NAMESPACE_COUNT:   ns_count_reg   <= cfg_wr_data[0];
                nvqte_pkg::REG_NAMESPACE_SECTORS: ns_sectors_reg <= cfg_wr_data;
                nvqte_pkg::REG_BUFFER_ADDRESS:    buf_addr_reg   <= cfg_wr_data;
                nvqte_pkg::REG_POLL_LIMIT:        poll_limit_reg <= cfg_wr_data[21:0];
                default: begin
                end
            endcase
        end
    end

    // Advance past the chunk just completed; poll count, status code, range check.
    assign left_after = (32'(chunk_reg) >= left_reg) ? 32'd0 : left_reg - 32'(chunk_reg);
    assign lba_after  = lba_reg + 64'(chunk_reg);
    assign code       = in_completion_status[11:1];
    assign poll_dec   = (polls_reg != 22'd0) ? polls_reg - 22'd1 : 22'd0;
    assign poll_load  = (poll_limit_reg == 22'd0) ? 22'd1 : poll_limit_reg;
    assign range_bad  = (in_start_lba > ns_sectors_reg) ||
                        ({32'd0, in_sector_count} > ns_sectors_reg - in_start_lba);

    // The submit source is the new request or the running one after a completion.
    always_comb begin
        if (in_mode == nvqte_pkg::MODE_REQUEST) begin
            sub_left  = in_sector_count;
            sub_lba   = in_start_lba;
            sub_write = in_is_write;
        end else begin
            sub_left  = left_after;
            sub_lba   = lba_after;
            sub_write = wflag_reg;
        end
    end

    // Build the submit, doorbell and finish results.
    assign chunk    = (sub_left > 32'(MAX_CHUNK)) ? MAX_CHUNK : sub_left[4:0];
    assign tail_inc = wrap_inc(tail_reg);
    assign head_inc = wrap_inc(head_reg);
    assign tail_ext = {4'b0000, tail_inc};
    assign head_ext = {4'b0000, head_inc};

    always_comb begin
        submit_res                     = '0;
        submit_res.kind                = nvqte_pkg::KIND_SUBMIT;
        submit_res.opcode              = sub_write ? nvqte_pkg::OP_WRITE : nvqte_pkg::OP_READ;
        submit_res.command_lba         = sub_lba;
        submit_res.blocks_minus_one    = 4'(chunk - 5'd1);
        submit_res.second_page_address = (chunk > nvqte_pkg::SECTORS_PER_PAGE) ?
                                         buf_addr_reg + nvqte_pkg::PAGE_BYTES : 64'd0;
        submit_res.doorbell_value      = tail_ext[3:0];

        bell_res                = '0;
        bell_res.kind           = nvqte_pkg::KIND_DOORBELL;
        bell_res.doorbell_value = head_ext[3:0];

        finish_res                = '0;
        finish_res.kind           = nvqte_pkg::KIND_FINISHED;
        finish_res.request_status = finish_status;
        finish_res.device_status  = finish_code;
    end

    // Per-item decision.
    always_comb begin
        tail_next     = tail_reg;
        head_next     = head_reg;
        phase_next    = phase_reg;
        busy_next     = busy_reg;
        lba_next      = lba_reg;
        left_next     = left_reg;
        chunk_next    = chunk_reg;
        wflag_next    = wflag_reg;
        polls_next    = polls_reg;
        task_push     = 1'b0;
        task_data     = '0;
        finish_status = nvqte_pkg::ST_OK;
        finish_code   = 11'd0;

        if (in_fire && in_mode == nvqte_pkg::MODE_REQUEST && !busy_reg) begin
            // New request: check namespace, count and range, then issue.
            task_push = 1'b1;
            if ({3'b000, ns_count_reg} <= in_namespace_index) begin
                finish_status   = nvqte_pkg::ST_NODEV;
                task_data.first = finish_res;
            end else if (in_sector_count == 32'd0) begin
                task_data.first = finish_res;
            end else if (range_bad) begin
                finish_status   = nvqte_pkg::ST_RANGE;
                task_data.first = finish_res;
            end else begin
                busy_next       = 1'b1;
                lba_next        = in_start_lba;
                left_next       = in_sector_count;
                wflag_next      = in_is_write;
                chunk_next      = chunk;
                tail_next       = tail_inc;
                polls_next      = poll_load;
                task_data.first = submit_res;
            end
        end else if (in_fire && in_mode == nvqte_pkg::MODE_STATUS && busy_reg) begin
            if (in_completion_status[0] == phase_reg) begin
                // Matching completion: ring the head doorbell, then go on.
                task_push       = 1'b1;
                task_data.two   = 1'b1;
                task_data.first = bell_res;
                head_next       = head_inc;
                if (head_inc == '0) begin
                    phase_next = ~phase_reg;
                end
                if (code != 11'd0) begin
                    busy_next        = 1'b0;
                    finish_status    = nvqte_pkg::ST_IOERR;
                    finish_code      = code;
                    task_data.second = finish_res;
                end else begin
                    lba_next  = lba_after;
                    left_next = left_after;
                    if (left_after == 32'd0) begin
                        busy_next        = 1'b0;
                        task_data.second = finish_res;
                    end else begin
                        chunk_next       = chunk;
                        tail_next        = tail_inc;
                        polls_next       = poll_load;
                        task_data.second = submit_res;
                    end
                end
            end else begin
                // Stale word: spend one poll, time out on the last one.
                polls_next = poll_dec;
                if (poll_dec == 22'd0) begin
                    busy_next       = 1'b0;
                    task_push       = 1'b1;
                    finish_status   = nvqte_pkg::ST_IOERR;
                    task_data.first = finish_res;
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tail_reg  <= '0;
            head_reg  <= '0;
            phase_reg <= 1'b1;
            busy_reg  <= 1'b0;
            lba_reg   <= '0;
            left_reg  <= '0;
            chunk_reg <= '0;
            wflag_reg <= 1'b0;
            polls_reg <= '0;
        end else begin
            tail_reg  <= tail_next;
            head_reg  <= head_next;
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            lba_reg   <= lba_next;
            left_reg  <= left_next;
            chunk_reg <= chunk_next;
            wflag_reg <= wflag_next;
            polls_reg <= polls_next;
        end
    end

endmodule

@@ hdl/nvqte_fifo.sv @@
// Short task queue between the front and the back of the transfer engine.
// Holds the results of a few accepted items. Depends on nvqte_pkg.
module nvqte_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  nvqte_pkg::task_t push_data,
    input  logic             pop,
    output nvqte_pkg::task_t head_data,
    output logic             empty,
    output logic             full
);

    localparam int DEPTH = nvqte_pkg::TASK_FIFO_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    nvqte_pkg::task_t slots_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign empty     = (count_reg == CW'(0));
    assign full      = (count_reg == CW'(DEPTH));
    assign head_data = slots_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Task storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hdl/nvqte_back.sv @@
// Back of the transfer engine: takes tasks from the queue and delivers their
// results one per transfer through an output register. Depends on nvqte_pkg.
module nvqte_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  nvqte_pkg::task_t   head_data,
    input  logic               empty,
    output logic               pop,
    input  logic               out_ready,
    output logic               out_valid,
    output nvqte_pkg::result_t out_res,
    output logic               out_last
);

    logic               out_valid_reg, out_valid_next;
    logic               out_last_reg, out_last_next;
    nvqte_pkg::result_t out_res_reg, out_res_next;
    logic               pend_valid_reg, pend_valid_next;
    nvqte_pkg::result_t pend_res_reg, pend_res_next;
    logic               slot_free;

    // The output register reloads whenever it is empty or being taken.
    assign slot_free = !out_valid_reg || out_ready;
    assign pop       = slot_free && !pend_valid_reg && !empty;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_last_next   = out_last_reg;
        out_res_next    = out_res_reg;
        pend_valid_next = pend_valid_reg;
        pend_res_next   = pend_res_reg;
        if (slot_free) begin
            if (pend_valid_reg) begin
                // Second result of a two-result task.
                out_valid_next  = 1'b1;
                out_res_next    = pend_res_reg;
                out_last_next   = 1'b1;
                pend_valid_next = 1'b0;
            end else if (!empty) begin
                out_valid_next  = 1'b1;
                out_res_next    = head_data.first;
                out_last_next   = !head_data.two;
                pend_valid_next = head_data.two;
                pend_res_next   = head_data.second;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        out_last_reg <= out_last_next;
        pend_res_reg <= pend_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_last  = out_last_reg;

endmodule

@@ hdl/nvme_io_queue_transfer_engine.sv @@
// Host-side NVMe I/O queue transfer engine, top level.
// Instantiates nvqte_front, nvqte_fifo and nvqte_back; depends on nvqte_pkg.
//
// The slave stream carries requests (s_tuser = 0) and polled completion
// status words (s_tuser = 1). The master stream carries submit commands,
// completion head doorbells and request-finished results, with m_tuser
// giving the kind and m_tlast marking the final result of one input.
// Registers are written through cfg_wr_en, cfg_index and cfg_wr_data; the
// user must do so only while the engine is idle, which is not enforced.
// An input transfer is decided in the cycle it is accepted; its first result
// passes the task queue and the output register to the master side, and the
// second follows once the first is taken. The engine accepts one item per
// cycle while its four-entry task queue has room, and delivers one result per
// cycle while m_tready is high; a two-result item uses the register twice.
// When the receiver stalls, results wait in the output register and the
// task queue, and s_tready falls once the queue is full.
// Reset clears the queue, the request state and the registers to their
// reset values; the engine is ready as soon as reset is released.
module nvme_io_queue_transfer_engine #(
    parameter int QUEUE_DEPTH       = 16,
    parameter int MAX_CHUNK_SECTORS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration write port.
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_wr_data,
    // Input stream.
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: namespace_index[3:0], start_lba[67:4], sector_count[99:68],
    //        is_write[100], completion_status[116:101], zero fill above.
    input  logic [119:0] s_tdata,
    // tuser: mode[0].
    input  logic         s_tuser,
    // Result stream.
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: opcode[1:0], command_lba[65:2], blocks_minus_one[69:66],
    //        second_page_address[133:70], doorbell_value[137:134],
    //        request_status[139:138], device_status[150:140], zero at 151.
    output logic [151:0] m_tdata,
    // tuser: kind[1:0].
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);

    logic               in_fire;
    logic               task_push;
    nvqte_pkg::task_t   task_data;
    nvqte_pkg::task_t   head_data;
    logic               fifo_empty;
    logic               fifo_full;
    logic               fifo_pop;
    nvqte_pkg::result_t out_res;

    assign s_tready = !fifo_full;
    assign in_fire  = s_tvalid && s_tready;

    // Front: decide each accepted item.
    nvqte_front #(
        .QUEUE_DEPTH       (QUEUE_DEPTH),
        .MAX_CHUNK_SECTORS (MAX_CHUNK_SECTORS)
    ) u_front (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wr_data          (cfg_wr_data),
        .in_fire              (in_fire),
        .in_mode              (s_tuser),
        .in_namespace_index   (s_tdata[3:0]),
        .in_start_lba         (s_tdata[67:4]),
        .in_sector_count      (s_tdata[99:68]),
        .in_is_write          (s_tdata[100]),
        .in_completion_status (s_tdata[116:101]),
        .task_push            (task_push),
        .task_data            (task_data)
    );

    // Task queue between front and back.
    nvqte_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (task_push),
        .push_data (task_data),
        .pop       (fifo_pop),
        .head_data (head_data),
        .empty     (fifo_empty),
        .full      (fifo_full)
    );

    // Back: deliver results one per transfer.
    nvqte_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_data (head_data),
        .empty     (fifo_empty),
        .pop       (fifo_pop),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_res   (out_res),
        .out_last  (m_tlast)
    );

    // Output packing.
    assign m_tuser = out_res.kind;
    assign m_tdata = {1'b0, out_res.device_status, out_res.request_status,
                      out_res.doorbell_value, out_res.second_page_address,
                      out_res.blocks_minus_one, out_res.command_lba, out_res.opcode};

    // A finished result always closes the results of its input.
    a_finish_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == nvqte_pkg::KIND_FINISHED) |-> m_tlast)
        else $error("finished result without tlast");

    // A doorbell is always followed by a further result of the same input.
    a_bell_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == nvqte_pkg::KIND_DOORBELL) |-> !m_tlast)
        else $error("doorbell result marked last");

    // A submit command always carries a read or write opcode.
    a_submit_opcode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == nvqte_pkg::KIND_SUBMIT) |->
        (m_tdata[1:0] == nvqte_pkg::OP_WRITE || m_tdata[1:0] == nvqte_pkg::OP_READ))
        else $error("submit result with bad opcode");

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        task_push |-> !fifo_full)
        else $error("task pushed into full queue");

endmodule

@@ test/nvme_io_queue_transfer_engine_test.sv @@
// Self-checking testbench for nvme_io_queue_transfer_engine: a directed table, then random
// request and completion traffic with random idling on both streams, checked against a predictor.
// Depends on nvqte_pkg and the engine RTL only.
module nvme_io_queue_transfer_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    import nvqte_pkg::*;

    localparam int          RING_SLOTS    = 16;
    localparam logic [31:0] CHUNK_LIMIT   = 32'd16;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          PHASES        = 13;
    localparam int          PHASE_ITEMS   = 150;

    // One input item, as the fields of the work it carries.
    typedef struct packed {
        logic        mode;
        logic [3:0]  ns_index;
        logic [63:0] start_lba;
        logic [31:0] sector_count;
        logic        is_write;
        logic [15:0] status_word;
    } xfer_item_t;

    // One result item together with its end-of-input marker.
    typedef struct packed {
        result_t res;
        logic    last;
    } engine_out_t;

    // Directed rows: predicted, typed-in finish, or a register write.
    typedef enum logic [1:0] {ROW_PREDICT, ROW_FINISH, ROW_WRITE} row_op_t;
    typedef struct packed {
        row_op_t     op;
        logic        mode;
        logic [3:0]  sel;     // namespace index, or register index for a write
        logic [63:0] value;   // start sector, or register value for a write
        logic [31:0] count;
        logic        wr;
        logic [15:0] word;
        logic [1:0]  code;    // typed request status of a finish row
    } stim_row_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [2:0]   cfg_index;
    logic [63:0]  cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    // tdata: namespace_index, start_lba, sector_count, is_write, completion_status.
    logic [119:0] s_tdata;
    // tuser: mode.
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // tdata: opcode, command_lba, blocks_minus_one, second_page_address,
    //        doorbell_value, request_status, device_status.
    logic [151:0] m_tdata;
    // tuser: kind.
    logic [1:0]   m_tuser;
    logic         m_tlast;

    // Registers as last written, seen by the predictor.
    logic        ns_present;
    logic [31:0] ns_ident;
    logic [63:0] ns_size;
    logic [63:0] bounce_addr;
    logic [21:0] poll_budget;

    // Queue pair and request state of the predictor.
    logic [3:0]  sq_tail;
    logic [3:0]  cq_head;
    logic        cq_phase;
    logic        xfer_busy;
    logic        xfer_write;
    logic [63:0] xfer_lba;
    logic [31:0] xfer_left;
    logic [4:0]  xfer_chunk;
    logic [21:0] polls_remaining;

    engine_out_t pending_results[$];
    int          mismatches;
    int          cycle_count;
    int          send_pace;
    int          recv_pace;
    logic        typed_row;
    logic [1:0]  typed_code;

    stim_row_t stim_rows [32] = '{
        '{ROW_FINISH,  MODE_REQUEST, 4'd0,  64'd0, 32'd5, 1'b0, 16'h0000, ST_NODEV},
        '{ROW_PREDICT, MODE_STATUS,  4'd0,  64'd0, 32'd0, 1'b0, 16'h0001, ST_OK},
        '{ROW_WRITE,   MODE_REQUEST, {1'b0, REG_NAMESPACE_COUNT},   64'd1,
          32'd0, 1'b0, 16'h0000, ST_OK},
        '{ROW_WRITE,   MODE_REQUEST, {1'b0, REG_NAMESPACE_ID},      64'hFFFF_FFFF,
          32'd0, 1'b0, 16'h0000, ST_OK},
        '{ROW_WRITE,   MODE_REQUEST, {1'b0, REG_NAMESPACE_SECTORS}, 64'd100,
          32'd0, 1'b0, 16'h0000, ST_OK},
        '{ROW_WRITE,   MODE_REQUEST, {1'b0, REG_BUFFER_ADDRESS},    64'hFFFF_FFFF_FFFF_F000,
          32'd0, 1'b0, 16'h0000, ST_OK},
        '{ROW_WRITE,   MODE_REQUEST, {1'b0, REG_POLL_LIMIT},        64'd3,
          32'd0, 1'b0, 16'h0000, ST_OK},
        '{ROW_FINISH,  MODE_REQUEST, 4'd15, 64'd0, 32'd1, 1'b0, 16'h0000, ST_NODEV},
        '{ROW_FINISH,  MODE_REQUEST, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b0,
          16'h0000, ST_OK},
        '{ROW_FINISH,  MODE_REQUEST, 4'd0,  64'd101, 32'd1, 1'b0, 16'h0000, ST_RANGE},
        '{ROW_FINISH,  MODE_REQUEST, 4'd0,  64'd90, 32'd11, 1'b0, 16'h0000, ST_RANGE},
        '{ROW_FINISH,  MODE_REQUEST, 4'd0,  64'd0, 32'hFFFF_FFFF, 1'b1, 16'h0000,
          ST_RANGE},
        '{ROW_PREDICT, MODE_REQUEST, 4'd0,  64'd0, 32'd100, 1'b1, 16'h0000, ST_OK},
        '{ROW_PREDICT, MODE_REQUEST, 4'd0,  64'd5, 32'd1, 1'b0, 16'h0000, ST_OK},
        '{ROW_PREDICT, MODE_STATUS,  4'd0,  64'd0, 32'd0, 1'b0, 16'h0000, ST_OK},
        '{ROW_PREDICT, MODE_STATUS,  4'd0,  64'd0, 32'd0, 1'b0, 16'hF001, ST_OK},
        '{ROW_PREDICT, MODE_STATUS,  4'd0,  64'd0, 32'd0, 1'b0, 16'hFFFF, ST_OK},
        '{ROW_PREDICT, MODE_REQUEST, 4'd0,  64'd99, 32'd1, 1'b0, 16'h0000, ST_OK},
        '{ROW_PREDICT, MODE_STATUS,  4'd0,  64'd0, 32'd0, 1'b0, 16'h0000, ST_OK},
        '{ROW_PREDICT, MODE_STATUS,  4'd0,  64'd0, 32'd0, 1'b0, 16'h0000, ST_OK},
        '{ROW_PREDICT, MODE_STATUS,  4'd0,  64'd0, 32'd0, 1'b0, 16'h0000, ST_OK},
        '{ROW_WRITE,   MODE_REQUEST, {1'b0, REG_POLL_LIMIT},        64'd0,
          32'd0, 1'b0, 16'h0000, ST_OK},
        '{ROW_WRITE,   MODE_REQUEST, {1'b0, REG_NAMESPACE_SECTORS}, 64'hFFFF_FFFF_FFFF_FFFF,
          32'd0, 1'b0, 16'h0000, ST_OK},
        '{ROW_PREDICT, MODE_REQUEST, 4'd0,  64'hFFFF_FFFF_FFFF_FFEF, 32'd17, 1'b1,
          16'h0000, ST_OK},
        '{ROW_PREDICT, MODE_STATUS,  4'd0,  64'd0, 32'd0, 1'b0, 16'h0000, ST_OK},
        '{ROW_PREDICT, MODE_REQUEST, 4'd0,  64'hFFFF_FFFF_FFFF_FFEF, 32'd17, 1'b0,
          16'h0000, ST_OK},
        '{ROW_PREDICT, MODE_STATUS,  4'd0,  64'd0, 32'd0, 1'b0, 16'h0001, ST_OK},
        '{ROW_PREDICT, MODE_STATUS,  4'd0,  64'd0, 32'd0, 1'b0, 16'h0001, ST_OK},
        '{ROW_FINISH,  MODE_REQUEST, 4'd0,  64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 1'b0,
          16'h0000, ST_RANGE},
        '{ROW_WRITE,   MODE_REQUEST, {1'b0, REG_POLL_LIMIT},        64'd4000000,
          32'd0, 1'b0, 16'h0000, ST_OK},
        '{ROW_PREDICT, MODE_REQUEST, 4'd0,  64'd0, 32'hFFFF_FFFF, 1'b0, 16'h0000, ST_OK},
        '{ROW_PREDICT, MODE_STATUS,  4'd0,  64'd0, 32'd0, 1'b0, 16'h0003, ST_OK}
    };

    nvme_io_queue_transfer_engine #(
        .QUEUE_DEPTH      (RING_SLOTS),
        .MAX_CHUNK_SECTORS(16)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // 12 ns clock.
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // A request-finished result with the given codes.
    function automatic engine_out_t finish_result(logic [1:0] code, logic [10:0] dev);
        engine_out_t r;
        r = '0;
        r.res.kind = KIND_FINISHED;
        r.res.request_status = code;
        r.res.device_status = dev;
        return r;
    endfunction

    // Issue the next chunk of the running request and advance the submission tail.
    function automatic engine_out_t issue_chunk();
        logic [31:0] sectors;
        engine_out_t r;
        sectors = (xfer_left > CHUNK_LIMIT) ? CHUNK_LIMIT : xfer_left;
        xfer_chunk = sectors[4:0];
        sq_tail = 4'((sq_tail + 1) % RING_SLOTS);
        polls_remaining = (poll_budget == '0) ? 22'd1 : poll_budget;
        r = '0;
        r.res.kind = KIND_SUBMIT;
        r.res.opcode = xfer_write ? OP_WRITE : OP_READ;
        r.res.command_lba = xfer_lba;
        r.res.blocks_minus_one = sectors[3:0] - 4'd1;
        r.res.second_page_address = (sectors > 32'(SECTORS_PER_PAGE)) ?
                                    bounce_addr + PAGE_BYTES : 64'd0;
        r.res.doorbell_value = sq_tail;
        return r;
    endfunction

    // Work out the results of one accepted item and advance the predicted state.
    function automatic int step_engine(input xfer_item_t it, output engine_out_t r0,
                                       output engine_out_t r1);
        int          n;
        logic [10:0] code;
        n = 0;
        r0 = '0;
        r1 = '0;
        if (it.mode == MODE_REQUEST) begin
            if (xfer_busy) begin
                return 0;
            end
            n = 1;
            if (it.ns_index >= {3'b000, ns_present}) begin
                r0 = finish_result(ST_NODEV, '0);
            end else if (it.sector_count == '0) begin
                r0 = finish_result(ST_OK, '0);
            end else if (it.start_lba > ns_size ||
                         {32'd0, it.sector_count} > ns_size - it.start_lba) begin
                r0 = finish_result(ST_RANGE, '0);
            end else begin
                xfer_busy = 1'b1;
                xfer_lba = it.start_lba;
                xfer_left = it.sector_count;
                xfer_write = it.is_write;
                r0 = issue_chunk();
            end
        end else begin
            if (!xfer_busy) begin
                return 0;
            end
            if (it.status_word[0] == cq_phase) begin
                // Phase matches: consume the entry, ring the head doorbell.
                code = it.status_word[11:1];
                cq_head = 4'((cq_head + 1) % RING_SLOTS);
                if (cq_head == '0) begin
                    cq_phase = ~cq_phase;
                end
                r0.res.kind = KIND_DOORBELL;
                r0.res.doorbell_value = cq_head;
                n = 2;
                if (code != '0) begin
                    xfer_busy = 1'b0;
                    r1 = finish_result(ST_IOERR, code);
                end else begin
                    xfer_lba = xfer_lba + 64'(xfer_chunk);
                    xfer_left = ({27'd0, xfer_chunk} >= xfer_left) ? 32'd0 :
                                xfer_left - 32'(xfer_chunk);
                    if (xfer_left == '0) begin
                        xfer_busy = 1'b0;
                        r1 = finish_result(ST_OK, '0);
                    end else begin
                        r1 = issue_chunk();
                    end
                end
            end else begin
                // Stale entry: spend one poll, time out when none are left.
                if (polls_remaining != '0) begin
                    polls_remaining = polls_remaining - 22'd1;
                end
                if (polls_remaining == '0) begin
                    xfer_busy = 1'b0;
                    n = 1;
                    r0 = finish_result(ST_IOERR, '0);
                end
            end
        end
        if (n == 1) begin
            r0.last = 1'b1;
        end else begin
            r1.last = 1'b1;
        end
        return n;
    endfunction

    function automatic string show_result(engine_out_t r);
        return $sformatf({"kind=%0d op=%0d lba=%h blocks-1=%0d page2=%h bell=%0d ",
                          "status=%0d dev=%h last=%0b"},
                         r.res.kind, r.res.opcode, r.res.command_lba,
                         r.res.blocks_minus_one, r.res.second_page_address,
                         r.res.doorbell_value, r.res.request_status,
                         r.res.device_status, r.last);
    endfunction

    // Track register writes and input transfers, and check each result transfer.
    always @(posedge aclk) begin : track_transfers
        int          n;
        xfer_item_t  seen;
        engine_out_t p0;
        engine_out_t p1;
        engine_out_t got;
        engine_out_t want;
        if (aresetn) begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_NAMESPACE_COUNT:   ns_present = cfg_wr_data[0];
                    REG_NAMESPACE_ID:      ns_ident = cfg_wr_data[31:0];
                    REG_NAMESPACE_SECTORS: ns_size = cfg_wr_data;
                    REG_BUFFER_ADDRESS:    bounce_addr = cfg_wr_data;
                    REG_POLL_LIMIT:        poll_budget = cfg_wr_data[21:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                seen.mode = s_tuser;
                seen.ns_index = s_tdata[3:0];
                seen.start_lba = s_tdata[67:4];
                seen.sector_count = s_tdata[99:68];
                seen.is_write = s_tdata[100];
                seen.status_word = s_tdata[116:101];
                n = step_engine(seen, p0, p1);
                if (typed_row) begin
                    want = finish_result(typed_code, '0);
                    want.last = 1'b1;
                    pending_results.push_back(want);
                end else begin
                    if (n > 0) pending_results.push_back(p0);
                    if (n > 1) pending_results.push_back(p1);
                end
            end
            if (m_tvalid && m_tready) begin
                got.res.kind = m_tuser;
                got.res.opcode = m_tdata[1:0];
                got.res.command_lba = m_tdata[65:2];
                got.res.blocks_minus_one = m_tdata[69:66];
                got.res.second_page_address = m_tdata[133:70];
                got.res.doorbell_value = m_tdata[137:134];
                got.res.request_status = m_tdata[139:138];
                got.res.device_status = m_tdata[150:140];
                got.last = m_tlast;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Result with nothing outstanding: %s", show_result(got));
                    end
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Result mismatch at %0t:\n  expected %s\n  actual   %s",
                                     $realtime, show_result(want), show_result(got));
                        end
                    end
                end
            end
        end
    end

    // Give up on a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: stall a random number of cycles before each transfer.
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            stall = $urandom_range(0, recv_pace);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    // Present one item after a random gap and hold it until it is taken.
    task automatic send_item(xfer_item_t it, logic typed, logic [1:0] code);
        int gap;
        gap = $urandom_range(0, send_pace);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.mode;
        s_tdata <= {3'b000, it.status_word, it.is_write, it.sector_count,
                    it.start_lba, it.ns_index};
        typed_row <= typed;
        typed_code <= code;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Wait until every predicted result has come out and the engine has gone quiet.
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic int draw_pace();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            default: return 11;
        endcase
    endfunction

    initial begin : stimulus
        xfer_item_t  it;
        int          phase;
        int          taken;
        int          pick;
        int          size_pick;
        logic [63:0] span;
        logic [63:0] draw64;
        logic [63:0] reg_val [5];

        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = MODE_REQUEST;
        typed_row = 1'b0;
        typed_code = ST_OK;
        mismatches = 0;
        cycle_count = 0;
        send_pace = 11;
        recv_pace = 11;

        // Predictor state after reset.
        ns_present = 1'b0;
        ns_ident = 32'd1;
        ns_size = '0;
        bounce_addr = '0;
        poll_budget = POLL_LIMIT_RESET;
        sq_tail = '0;
        cq_head = '0;
        cq_phase = 1'b1;
        xfer_busy = 1'b0;
        xfer_write = 1'b0;
        xfer_lba = '0;
        xfer_left = '0;
        xfer_chunk = '0;
        polls_remaining = '0;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part.
        foreach (stim_rows[i]) begin
            if (stim_rows[i].op == ROW_WRITE) begin
                settle_idle();
                write_reg(stim_rows[i].sel[2:0], stim_rows[i].value);
            end else begin
                it.mode = stim_rows[i].mode;
                it.ns_index = stim_rows[i].sel;
                it.start_lba = stim_rows[i].value;
                it.sector_count = stim_rows[i].count;
                it.is_write = stim_rows[i].wr;
                it.status_word = stim_rows[i].word;
                send_item(it, stim_rows[i].op == ROW_FINISH, stim_rows[i].code);
            end
        end

        // Random part, one register setting per phase.
        for (phase = 0; phase < PHASES; phase++) begin
            settle_idle();
            reg_val[REG_NAMESPACE_COUNT] = ($urandom_range(0, 9) == 0) ? 64'd0 : 64'd1;
            reg_val[REG_NAMESPACE_ID] = {32'd0, $urandom};
            case ($urandom_range(0, 4))
                0:       reg_val[REG_NAMESPACE_SECTORS] = 64'($urandom_range(1, 300));
                1:       reg_val[REG_NAMESPACE_SECTORS] = {32'd0, $urandom};
                2:       reg_val[REG_NAMESPACE_SECTORS] = '1;
                3:       reg_val[REG_NAMESPACE_SECTORS] = {$urandom, $urandom};
                default: reg_val[REG_NAMESPACE_SECTORS] = 64'($urandom_range(16, 64));
            endcase
            draw64 = {$urandom, $urandom};
            draw64[11:0] = '0;
            reg_val[REG_BUFFER_ADDRESS] = draw64;
            case ($urandom_range(0, 6))
                0:       reg_val[REG_POLL_LIMIT] = 64'd0;
                1:       reg_val[REG_POLL_LIMIT] = 64'd1;
                2:       reg_val[REG_POLL_LIMIT] = 64'd4000000;
                3:       reg_val[REG_POLL_LIMIT] = 64'h3F_FFFF;
                default: reg_val[REG_POLL_LIMIT] = 64'($urandom_range(2, 20));
            endcase
            // Low extremes in the first phase, high ones in the second, no device in the third.
            if (phase == 0) begin
                reg_val[REG_NAMESPACE_COUNT] = 64'd1;
                reg_val[REG_NAMESPACE_ID] = 64'd0;
                reg_val[REG_NAMESPACE_SECTORS] = 64'd1;
                reg_val[REG_BUFFER_ADDRESS] = 64'd0;
                reg_val[REG_POLL_LIMIT] = 64'd1;
            end else if (phase == 1) begin
                reg_val[REG_NAMESPACE_COUNT] = 64'd1;
                reg_val[REG_NAMESPACE_ID] = 64'hFFFF_FFFF;
                reg_val[REG_NAMESPACE_SECTORS] = '1;
                reg_val[REG_BUFFER_ADDRESS] = 64'hFFFF_FFFF_FFFF_F000;
                reg_val[REG_POLL_LIMIT] = 64'd4000000;
            end else if (phase == 2) begin
                reg_val[REG_NAMESPACE_COUNT] = 64'd0;
            end
            write_reg(REG_NAMESPACE_COUNT, reg_val[REG_NAMESPACE_COUNT]);
            write_reg(REG_NAMESPACE_ID, reg_val[REG_NAMESPACE_ID]);
            write_reg(REG_NAMESPACE_SECTORS, reg_val[REG_NAMESPACE_SECTORS]);
            write_reg(REG_BUFFER_ADDRESS, reg_val[REG_BUFFER_ADDRESS]);
            write_reg(REG_POLL_LIMIT, reg_val[REG_POLL_LIMIT]);
            send_pace = draw_pace();
            recv_pace = draw_pace();

            taken = 0;
            while (taken < PHASE_ITEMS) begin
                it.ns_index = 4'($urandom);
                it.start_lba = {$urandom, $urandom};
                it.sector_count = $urandom;
                it.is_write = 1'($urandom);
                it.status_word = 16'($urandom);
                pick = $urandom_range(0, 99);
                if (!xfer_busy) begin
                    // Idle: mostly well-formed requests, some malformed, a few stray words.
                    it.mode = (pick < 90) ? MODE_REQUEST : MODE_STATUS;
                    if (pick < 75) begin
                        it.ns_index = '0;
                        size_pick = $urandom_range(0, 19);
                        if (size_pick < 15) begin
                            it.sector_count = $urandom_range(1, 40);
                        end else if (size_pick < 18) begin
                            it.sector_count = $urandom_range(0, 600);
                        end
                        if (ns_size >= {32'd0, it.sector_count}) begin
                            span = ns_size - {32'd0, it.sector_count};
                            draw64 = {$urandom, $urandom};
                            if ($urandom_range(0, 7) == 0) begin
                                it.start_lba = span;
                            end else if (span == '1) begin
                                it.start_lba = draw64;
                            end else begin
                                it.start_lba = draw64 % (span + 64'd1);
                            end
                        end
                    end
                end else begin
                    // Busy: mostly good completions, some errors, stale entries, stray requests.
                    it.mode = (pick < 90) ? MODE_STATUS : MODE_REQUEST;
                    if (pick < 70) begin
                        it.status_word[11:0] = {11'd0, cq_phase};
                    end else if (pick < 76) begin
                        it.status_word[0] = cq_phase;
                    end else begin
                        it.status_word[0] = ~cq_phase;
                    end
                end
                taken++;
                send_item(it, 1'b0, ST_OK);
            end

            // End any running request with a device error before the next setting.
            while (xfer_busy) begin
                it = '0;
                it.mode = MODE_STATUS;
                it.status_word = {4'($urandom), 11'($urandom_range(1, 2047)), cq_phase};
                send_item(it, 1'b0, ST_OK);
            end
        end

        settle_idle();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
